>>> rtl/wsd_pkg.sv
package wsd_pkg;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMTID, PH_FMTSIZE, PH_CODE, PH_CHANS, PH_RATE,
    PH_BRATE, PH_ALIGN, PH_BITS, PH_CID, PH_CSIZE, PH_SKIP, PH_DATA, PH_IDLE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NOT_RIFF = 3'd1,
    ERR_NOT_WAVE = 3'd2,
    ERR_OVER_32  = 3'd3,
    ERR_DEPTH    = 3'd4,
    ERR_FORMAT   = 3'd5,
    ERR_NO_DATA  = 3'd6
  } err_e;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [15:0] FmtPcm = 16'd1;
  localparam logic [15:0] FmtFloat = 16'd3;

  // result item: 2+16+32+1+16+32+32+16+3+1 = 151 bits
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] channel_index;
    logic [31:0] sample_value;
    logic        is_float;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [31:0] data_bytes;
    logic [15:0] block_align;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

  localparam int unsigned QDepth = 2;

endpackage

>>> rtl/wsd_parser.sv
// front part: parses headers and assembles samples, one byte per cycle while the queue has space
module wsd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       byte_i,
  input  logic             end_i,
  output logic             res_valid_o,
  output wsd_pkg::result_t res_o,
  input  logic             q_space_i
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] fmt_q, fmt_d, chans_q, chans_d, align_q, align_d, bits_q, bits_d;
  logic [31:0] rate_q, rate_d, chunk_q, chunk_d, drem_q, drem_d, asm_q, asm_d;
  logic [15:0] chan_q, chan_d;

  logic        fire;
  logic [2:0]  need;
  logic [31:0] gval;
  logic        gdone;
  logic [2:0]  wid;

  assign in_ready_o = q_space_i;
  assign fire = in_valid_i && q_space_i;

  // gather helper values
  always_comb begin
    gval  = shift_q | ({24'd0, byte_i} << {cnt_q[1:0], 3'd0});
    gdone = ({1'b0, cnt_q} + 4'd1) >= {1'b0, need};
  end

  // sample width in bytes
  always_comb begin
    if (fmt_q == wsd_pkg::FmtFloat) wid = 3'd4;
    else wid = bits_q[5:3];
    if (wid == 3'd0 || wid > 3'd4) wid = 3'd4;
  end

  always_comb begin
    logic [31:0] sa;
    logic [15:0] cn;
    phase_d = phase_q; cnt_d = cnt_q; shift_d = shift_q; fmt_d = fmt_q;
    chans_d = chans_q; rate_d = rate_q; align_d = align_q; bits_d = bits_q;
    chunk_d = chunk_q; drem_d = drem_q; chan_d = chan_q; asm_d = asm_q;
    res_valid_o = 1'b0;
    res_o = '0;
    sa = '0;
    cn = '0;
    case (phase_q)
      wsd_pkg::PH_CODE, wsd_pkg::PH_CHANS, wsd_pkg::PH_ALIGN,
      wsd_pkg::PH_BITS: need = 3'd2;
      default:          need = 3'd4;
    endcase
    if (fire) begin
      if (phase_q < wsd_pkg::PH_SKIP) begin
        if (gdone) begin
          shift_d = '0; cnt_d = '0;
        end else begin
          shift_d = gval; cnt_d = cnt_q + 3'd1;
        end
      end
      case (phase_q)
        wsd_pkg::PH_RIFF: if (gdone) begin
          if (gval != wsd_pkg::TagRiff) begin
            res_valid_o = 1'b1; res_o.kind = wsd_pkg::KIND_ERROR;
            res_o.error_code = wsd_pkg::ERR_NOT_RIFF; phase_d = wsd_pkg::PH_IDLE;
          end else phase_d = wsd_pkg::PH_RSIZE;
        end
        wsd_pkg::PH_RSIZE: if (gdone) phase_d = wsd_pkg::PH_WAVE;
        wsd_pkg::PH_WAVE: if (gdone) begin
          if (gval != wsd_pkg::TagWave) begin
            res_valid_o = 1'b1; res_o.kind = wsd_pkg::KIND_ERROR;
            res_o.error_code = wsd_pkg::ERR_NOT_WAVE; phase_d = wsd_pkg::PH_IDLE;
          end else phase_d = wsd_pkg::PH_FMTID;
        end
        wsd_pkg::PH_FMTID: if (gdone) phase_d = wsd_pkg::PH_FMTSIZE;
        wsd_pkg::PH_FMTSIZE: if (gdone) begin
          chunk_d = gval; phase_d = wsd_pkg::PH_CODE;
        end
        wsd_pkg::PH_CODE: if (gdone) begin
          fmt_d = gval[15:0]; phase_d = wsd_pkg::PH_CHANS;
        end
        wsd_pkg::PH_CHANS: if (gdone) begin
          chans_d = gval[15:0]; phase_d = wsd_pkg::PH_RATE;
        end
        wsd_pkg::PH_RATE: if (gdone) begin
          rate_d = gval; phase_d = wsd_pkg::PH_BRATE;
        end
        wsd_pkg::PH_BRATE: if (gdone) phase_d = wsd_pkg::PH_ALIGN;
        wsd_pkg::PH_ALIGN: if (gdone) begin
          align_d = gval[15:0]; phase_d = wsd_pkg::PH_BITS;
        end
        wsd_pkg::PH_BITS: if (gdone) begin
          bits_d = gval[15:0];
          if (gval[15:0] > 16'd32) begin
            res_valid_o = 1'b1; res_o.kind = wsd_pkg::KIND_ERROR;
            res_o.error_code = wsd_pkg::ERR_OVER_32; phase_d = wsd_pkg::PH_IDLE;
          end else if (chunk_q > 32'd16) begin
            chunk_d = chunk_q - 32'd16; phase_d = wsd_pkg::PH_SKIP;
          end else begin
            chunk_d = '0; phase_d = wsd_pkg::PH_CID;
          end
        end
        wsd_pkg::PH_CID: if (gdone) begin
          asm_d = gval; phase_d = wsd_pkg::PH_CSIZE;
        end
        wsd_pkg::PH_CSIZE: if (gdone) begin
          if (asm_q == wsd_pkg::TagData) begin
            drem_d = gval;
            res_valid_o = 1'b1;
            if (fmt_q == wsd_pkg::FmtPcm && !(bits_q == 16'd8 || bits_q == 16'd16 ||
                bits_q == 16'd24 || bits_q == 16'd32)) begin
              res_o.kind = wsd_pkg::KIND_ERROR;
              res_o.error_code = wsd_pkg::ERR_DEPTH; phase_d = wsd_pkg::PH_IDLE;
            end else if (fmt_q != wsd_pkg::FmtPcm && fmt_q != wsd_pkg::FmtFloat) begin
              res_o.kind = wsd_pkg::KIND_ERROR;
              res_o.error_code = wsd_pkg::ERR_FORMAT; phase_d = wsd_pkg::PH_IDLE;
            end else begin
              res_o.kind = wsd_pkg::KIND_REPORT;
              res_o.channel_count = chans_q; res_o.rate_hz = rate_q;
              res_o.data_bytes = gval; res_o.block_align = align_q;
              chan_d = '0; asm_d = '0;
              if (align_q == 16'd0 || chans_q == 16'd0 || gval < {16'd0, align_q})
                phase_d = wsd_pkg::PH_IDLE;
              else begin
                drem_d = gval - {16'd0, align_q}; phase_d = wsd_pkg::PH_DATA;
              end
            end
          end else begin
            chunk_d = gval;
            phase_d = (gval != 32'd0) ? wsd_pkg::PH_SKIP : wsd_pkg::PH_CID;
          end
        end
        wsd_pkg::PH_SKIP: begin
          chunk_d = chunk_q - 32'd1;
          if (chunk_q == 32'd1) phase_d = wsd_pkg::PH_CID;
        end
        wsd_pkg::PH_DATA: begin
          sa = asm_q | ({24'd0, byte_i} << {cnt_q[1:0], 3'd0});
          if (cnt_q + 3'd1 < wid) begin
            asm_d = sa; cnt_d = cnt_q + 3'd1;
          end else begin
            res_valid_o = 1'b1;
            res_o.kind = wsd_pkg::KIND_SAMPLE;
            res_o.channel_index = chan_q;
            if (fmt_q == wsd_pkg::FmtFloat) begin
              res_o.sample_value = sa; res_o.is_float = 1'b1;
            end else begin
              case (wid)
                3'd1:    res_o.sample_value = {sa[7:0] - 8'd128, 24'd0};
                3'd2:    res_o.sample_value = {sa[15:0], 16'd0};
                3'd3:    res_o.sample_value = {sa[23:0], 8'd0};
                default: res_o.sample_value = sa;
              endcase
            end
            asm_d = '0; cnt_d = '0;
            cn = chan_q + 16'd1;
            chan_d = cn;
            if (cn >= chans_q) begin
              chan_d = '0;
              if (drem_q >= {16'd0, align_q}) drem_d = drem_q - {16'd0, align_q};
              else begin
                res_o.last = 1'b1; phase_d = wsd_pkg::PH_IDLE;
              end
            end
          end
        end
        default: ;
      endcase
      // stream end resets the parser
      if (end_i) begin
        if (!res_valid_o && phase_q < wsd_pkg::PH_DATA && phase_d < wsd_pkg::PH_DATA) begin
          res_valid_o = 1'b1; res_o = '0; res_o.kind = wsd_pkg::KIND_ERROR;
          res_o.error_code = wsd_pkg::ERR_NO_DATA;
        end
        phase_d = wsd_pkg::PH_RIFF; cnt_d = '0; shift_d = '0; fmt_d = '0;
        chans_d = '0; rate_d = '0; align_d = '0; bits_d = '0; chunk_d = '0;
        drem_d = '0; chan_d = '0; asm_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wsd_pkg::PH_RIFF; cnt_q <= '0; shift_q <= '0; fmt_q <= '0;
      chans_q <= '0; rate_q <= '0; align_q <= '0; bits_q <= '0; chunk_q <= '0;
      drem_q <= '0; chan_q <= '0; asm_q <= '0;
    end else begin
      phase_q <= phase_d; cnt_q <= cnt_d; shift_q <= shift_d; fmt_q <= fmt_d;
      chans_q <= chans_d; rate_q <= rate_d; align_q <= align_d; bits_q <= bits_d;
      chunk_q <= chunk_d; drem_q <= drem_d; chan_q <= chan_d; asm_q <= asm_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_res_unless_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> fire) else $error("result without item");
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && end_i) |=> phase_q == wsd_pkg::PH_RIFF) else $error("end not reset");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < 3'd4) else $error("byte count overrun");
`endif

endmodule

>>> rtl/wsd_queue.sv
// back part: short result queue feeding the output port
module wsd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wsd_pkg::result_t data_i,
  output logic             space_o,
  output logic             valid_o,
  output wsd_pkg::result_t data_o,
  input  logic             ready_i
);

  localparam int unsigned AW = $clog2(wsd_pkg::QDepth);

  wsd_pkg::result_t mem_q [wsd_pkg::QDepth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          pop;

  assign pop = valid_o && ready_i;
  assign valid_o = cnt_q != '0;
  assign space_o = cnt_q != (AW+1)'(wsd_pkg::QDepth);
  assign data_o = mem_q[rd_q];

  // storage, written only on push
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop) rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o) else $error("queue overflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(wsd_pkg::QDepth)) else $error("count out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o) else $error("item dropped");
`endif

endmodule

>>> rtl/wave_stream_decoder.sv
// Byte-serial WAVE decoder: takes one file byte per cycle on the slave side
// (tlast marks the final byte of the file) and gives at most one result item
// per byte on the master side: a format report once the data chunk header is
// complete, then each sample as left-aligned Q1.31 (raw bits for float), or an
// error code. tuser carries the kind and the float flag, tlast flags the final
// sample of the data chunk. The parser settles each byte combinationally; a
// two-entry result queue holds up to two waiting results, so the input stalls
// only while both entries are taken, and throughput is one byte per cycle
// whenever results are drained. Each result is registered in the queue.
module wave_stream_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,  // data_byte
  input  logic          s_axis_tlast,  // stream_end
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // channel_index, sample_value, channel_count, rate_hz, data_bytes,
  // block_align, error_code (from bit 0 up), zero-filled
  output logic [151:0]  m_axis_tdata,
  output logic [2:0]    m_axis_tuser,  // kind, is_float (from bit 0 up)
  output logic          m_axis_tlast   // last
);

  logic             res_valid, q_space;
  wsd_pkg::result_t res, qout;

  wsd_parser u_parser (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .byte_i (s_axis_tdata), .end_i (s_axis_tlast),
    .res_valid_o (res_valid), .res_o (res), .q_space_i (q_space)
  );

  wsd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (res_valid), .data_i (res), .space_o (q_space),
    .valid_o (m_axis_tvalid), .data_o (qout), .ready_i (m_axis_tready)
  );

  // first field in the lowest bits
  assign m_axis_tdata = {5'd0, qout.error_code, qout.block_align,
    qout.data_bytes, qout.rate_hz, qout.channel_count,
    qout.sample_value, qout.channel_index};
  assign m_axis_tuser = {qout.is_float, qout.kind};
  assign m_axis_tlast = qout.last;

endmodule

>>> tb/wave_result_checker.sv
module wave_result_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [151:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    wsd_pkg::kind_e kind;
    logic [15:0] chan_idx;
    logic [31:0] value;
    logic        flt;
    logic [15:0] chan_cnt;
    logic [31:0] srate;
    logic [31:0] dbytes;
    logic [15:0] balign;
    wsd_pkg::err_e err;
    logic        lst;
  } wave_res_t;

  wave_res_t   expected_q[$];
  int          fails = 0;

  // decoder state mirror
  wsd_pkg::phase_e ph;
  logic [2:0]  fld_cnt;
  logic [31:0] fld_shift;
  logic [15:0] fmt_code;
  logic [15:0] n_chans;
  logic [31:0] s_rate;
  logic [15:0] frame_len;
  logic [15:0] bits_per;
  logic [31:0] chunk_left;
  logic [31:0] data_left;
  logic [15:0] chan_ctr;
  logic [31:0] assembly;

  assign pending_o = expected_q.size();
  assign fail_count_o = fails;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  task clear_state();
    ph = wsd_pkg::PH_RIFF;
    fld_cnt = '0;
    fld_shift = '0;
    fmt_code = '0;
    n_chans = '0;
    s_rate = '0;
    frame_len = '0;
    bits_per = '0;
    chunk_left = '0;
    data_left = '0;
    chan_ctr = '0;
    assembly = '0;
  endtask

  function automatic wave_res_t blank_res();
    wave_res_t r;
    r.kind = wsd_pkg::KIND_SAMPLE;
    r.chan_idx = '0;
    r.value = '0;
    r.flt = 1'b0;
    r.chan_cnt = '0;
    r.srate = '0;
    r.dbytes = '0;
    r.balign = '0;
    r.err = wsd_pkg::ERR_NONE;
    r.lst = 1'b0;
    return r;
  endfunction

  // little-endian field assembly, done once width bytes are in
  task gather_field(input logic [7:0] b, input int unsigned width, output bit done,
                    output logic [31:0] v);
    fld_shift = fld_shift | (32'(b) << (8 * fld_cnt[1:0]));
    done = 1'b0;
    v = '0;
    if (int'(fld_cnt) + 1 >= width) begin
      v = fld_shift;
      fld_shift = '0;
      fld_cnt = '0;
      done = 1'b1;
    end else begin
      fld_cnt = fld_cnt + 3'd1;
    end
  endtask

  task raise_error(input wsd_pkg::err_e code, output bit got, output wave_res_t r);
    r = blank_res();
    r.kind = wsd_pkg::KIND_ERROR;
    r.err = code;
    ph = wsd_pkg::PH_IDLE;
    got = 1'b1;
  endtask

  // data header complete: validate then report and open the first frame
  task open_data(output bit got, output wave_res_t r);
    if (fmt_code == wsd_pkg::FmtPcm &&
        !(bits_per inside {16'd8, 16'd16, 16'd24, 16'd32})) begin
      raise_error(wsd_pkg::ERR_DEPTH, got, r);
    end else if (fmt_code != wsd_pkg::FmtPcm && fmt_code != wsd_pkg::FmtFloat) begin
      raise_error(wsd_pkg::ERR_FORMAT, got, r);
    end else begin
      r = blank_res();
      r.kind = wsd_pkg::KIND_REPORT;
      r.chan_cnt = n_chans;
      r.srate = s_rate;
      r.dbytes = data_left;
      r.balign = frame_len;
      got = 1'b1;
      chan_ctr = '0;
      assembly = '0;
      if (frame_len == 0 || n_chans == 0 || data_left < 32'(frame_len)) begin
        ph = wsd_pkg::PH_IDLE;
      end else begin
        data_left = data_left - 32'(frame_len);
        ph = wsd_pkg::PH_DATA;
      end
    end
  endtask

  task decode_byte(input logic [7:0] b, output bit got, output wave_res_t r);
    bit done;
    logic [31:0] v;
    int unsigned width;
    got = 1'b0;
    r = blank_res();
    case (ph)
      wsd_pkg::PH_RIFF: begin
        gather_field(b, 4, done, v);
        if (done) begin
          if (v != wsd_pkg::TagRiff) raise_error(wsd_pkg::ERR_NOT_RIFF, got, r);
          else ph = wsd_pkg::PH_RSIZE;
        end
      end
      wsd_pkg::PH_RSIZE: begin
        gather_field(b, 4, done, v);
        if (done) ph = wsd_pkg::PH_WAVE;
      end
      wsd_pkg::PH_WAVE: begin
        gather_field(b, 4, done, v);
        if (done) begin
          if (v != wsd_pkg::TagWave) raise_error(wsd_pkg::ERR_NOT_WAVE, got, r);
          else ph = wsd_pkg::PH_FMTID;
        end
      end
      wsd_pkg::PH_FMTID: begin
        gather_field(b, 4, done, v);
        if (done) ph = wsd_pkg::PH_FMTSIZE;
      end
      wsd_pkg::PH_FMTSIZE: begin
        gather_field(b, 4, done, v);
        if (done) begin
          chunk_left = v;
          ph = wsd_pkg::PH_CODE;
        end
      end
      wsd_pkg::PH_CODE: begin
        gather_field(b, 2, done, v);
        if (done) begin
          fmt_code = v[15:0];
          ph = wsd_pkg::PH_CHANS;
        end
      end
      wsd_pkg::PH_CHANS: begin
        gather_field(b, 2, done, v);
        if (done) begin
          n_chans = v[15:0];
          ph = wsd_pkg::PH_RATE;
        end
      end
      wsd_pkg::PH_RATE: begin
        gather_field(b, 4, done, v);
        if (done) begin
          s_rate = v;
          ph = wsd_pkg::PH_BRATE;
        end
      end
      wsd_pkg::PH_BRATE: begin
        gather_field(b, 4, done, v);
        if (done) ph = wsd_pkg::PH_ALIGN;
      end
      wsd_pkg::PH_ALIGN: begin
        gather_field(b, 2, done, v);
        if (done) begin
          frame_len = v[15:0];
          ph = wsd_pkg::PH_BITS;
        end
      end
      wsd_pkg::PH_BITS: begin
        gather_field(b, 2, done, v);
        if (done) begin
          bits_per = v[15:0];
          if (bits_per > 16'd32) begin
            raise_error(wsd_pkg::ERR_OVER_32, got, r);
          end else begin
            chunk_left = (chunk_left > 32'd16) ? chunk_left - 32'd16 : 32'd0;
            ph = (chunk_left != 0) ? wsd_pkg::PH_SKIP : wsd_pkg::PH_CID;
          end
        end
      end
      wsd_pkg::PH_CID: begin
        gather_field(b, 4, done, v);
        if (done) begin
          assembly = v;
          ph = wsd_pkg::PH_CSIZE;
        end
      end
      wsd_pkg::PH_CSIZE: begin
        gather_field(b, 4, done, v);
        if (done) begin
          if (assembly == wsd_pkg::TagData) begin
            data_left = v;
            open_data(got, r);
          end else begin
            chunk_left = v;
            ph = (v != 0) ? wsd_pkg::PH_SKIP : wsd_pkg::PH_CID;
          end
        end
      end
      wsd_pkg::PH_SKIP: begin
        chunk_left = chunk_left - 32'd1;
        if (chunk_left == 0) ph = wsd_pkg::PH_CID;
      end
      wsd_pkg::PH_DATA: begin
        width = (fmt_code == wsd_pkg::FmtFloat) ? 4 : int'((bits_per >> 3) & 16'd7);
        if (width == 0 || width > 4) width = 4;
        assembly = assembly | (32'(b) << (8 * fld_cnt[1:0]));
        if (int'(fld_cnt) + 1 < width) begin
          fld_cnt = fld_cnt + 3'd1;
        end else begin
          got = 1'b1;
          r.chan_idx = chan_ctr;
          if (fmt_code == wsd_pkg::FmtFloat) begin
            r.value = assembly;
            r.flt = 1'b1;
          end else begin
            case (width)
              1: r.value = {assembly[7:0] ^ 8'h80, 24'h0};
              2: r.value = {assembly[15:0], 16'h0};
              3: r.value = {assembly[23:0], 8'h0};
              default: r.value = assembly;
            endcase
          end
          assembly = '0;
          fld_cnt = '0;
          chan_ctr = chan_ctr + 16'd1;
          if (chan_ctr >= n_chans) begin
            chan_ctr = '0;
            if (data_left >= 32'(frame_len)) begin
              data_left = data_left - 32'(frame_len);
            end else begin
              r.lst = 1'b1;
              ph = wsd_pkg::PH_IDLE;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // predict on accepted bytes, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    bit got;
    wave_res_t r;
    wave_res_t e;
    logic [151:0] d;
    logic [2:0] u;
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, got, r);
        if (s_axis_tlast) begin
          if (!got && ph < wsd_pkg::PH_DATA) raise_error(wsd_pkg::ERR_NO_DATA, got, r);
          clear_state();
        end
        if (got) expected_q.push_back(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        d = m_axis_tdata;
        u = m_axis_tuser;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result item %h %h", u, d));
        end else begin
          e = expected_q.pop_front();
          if (u[1:0] != e.kind)
            report_mismatch($sformatf("kind %0d, want %0d", u[1:0], e.kind));
          if (d[15:0] != e.chan_idx)
            report_mismatch($sformatf("channel_index %0d, want %0d", d[15:0], e.chan_idx));
          if (d[47:16] != e.value)
            report_mismatch($sformatf("sample_value %h, want %h", d[47:16], e.value));
          if (u[2] != e.flt)
            report_mismatch($sformatf("is_float %0b, want %0b", u[2], e.flt));
          if (d[63:48] != e.chan_cnt)
            report_mismatch($sformatf("channel_count %0d, want %0d", d[63:48], e.chan_cnt));
          if (d[95:64] != e.srate)
            report_mismatch($sformatf("rate_hz %h, want %h", d[95:64], e.srate));
          if (d[127:96] != e.dbytes)
            report_mismatch($sformatf("data_bytes %h, want %h", d[127:96], e.dbytes));
          if (d[143:128] != e.balign)
            report_mismatch($sformatf("block_align %0d, want %0d", d[143:128], e.balign));
          if (d[146:144] != e.err)
            report_mismatch($sformatf("error_code %0d, want %0d", d[146:144], e.err));
          if (m_axis_tlast != e.lst)
            report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast, e.lst));
          if (d[151:147] != 5'd0)
            report_mismatch("padding bits set");
        end
      end
    end
  end

endmodule

>>> tb/tb_wave_stream_decoder.sv
module tb_wave_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  logic [7:0] file_q[$];

  always #2 clk_i = ~clk_i;

  wave_stream_decoder u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  wave_result_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count),
    .pending_o(pending)
  );

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic push16(input logic [15:0] v);
    file_q.push_back(v[7:0]);
    file_q.push_back(v[15:8]);
  endtask

  task automatic push32(input logic [31:0] v);
    push16(v[15:0]);
    push16(v[31:16]);
  endtask

  task automatic send_item(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // build one file; bad_tag 1 breaks the riff tag, 2 the wave tag;
  // cut > 0 truncates the whole file to that many bytes
  task automatic send_wave(input logic [15:0] fmt, input logic [15:0] chans,
                           input logic [31:0] rate, input logic [15:0] align,
                           input logic [15:0] bits, input logic [31:0] fmt_size,
                           input int n_extra, input logic [31:0] dsize,
                           input int n_data, input int n_tail, input int bad_tag,
                           input int cut);
    logic [31:0] cid;
    int csz;
    int n;
    file_q.delete();
    push32(bad_tag == 1 ? wsd_pkg::TagRiff ^ (32'h1 << $urandom_range(31))
                        : wsd_pkg::TagRiff);
    push32($urandom);
    push32(bad_tag == 2 ? wsd_pkg::TagWave ^ (32'h1 << $urandom_range(31))
                        : wsd_pkg::TagWave);
    push32(32'h2074_6d66);
    push32(fmt_size);
    push16(fmt);
    push16(chans);
    push32(rate);
    push32($urandom);
    push16(align);
    push16(bits);
    // long fmt chunk tail
    if (fmt_size > 16) repeat (fmt_size - 16) file_q.push_back(8'($urandom));
    // unrelated chunk sizes and payloads ahead of data; the drawn cid is never pushed
    repeat (n_extra) begin
      cid = $urandom;
      if (cid == wsd_pkg::TagData) cid[0] = ~cid[0];
      csz = $urandom_range(0, 5);
      push32(csz);
      repeat (csz) file_q.push_back(8'($urandom));
    end
    push32(wsd_pkg::TagData);
    push32(dsize);
    repeat (n_data) file_q.push_back(8'($urandom));
    repeat (n_tail) file_q.push_back(8'($urandom));
    if (cut > 0 && cut < file_q.size()) file_q = file_q[0:cut-1];
    n = file_q.size();
    for (int i = 0; i < n; i++) send_item(file_q[i], i == n - 1);
  endtask

  // mostly well-formed files with random content, some broken or noise
  task automatic random_file();
    int sel;
    int bps;
    logic [15:0] fmt;
    logic [15:0] chans;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] fsz;
    logic [31:0] dsize;
    int frames;
    int n_data;
    int n;
    sel = $urandom_range(99);
    if (sel < 6) begin
      // pure noise
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) send_item(8'($urandom), i == n - 1);
      return;
    end
    fmt = ($urandom_range(3) == 0) ? wsd_pkg::FmtFloat : wsd_pkg::FmtPcm;
    bps = $urandom_range(1, 4);
    bits = (fmt == wsd_pkg::FmtFloat) ? 16'd32 : 16'(8 * bps);
    if (fmt == wsd_pkg::FmtFloat) bps = 4;
    chans = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
    align = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 12)) : 16'(chans * bps);
    fsz = ($urandom_range(4) == 0) ? 32'($urandom_range(0, 21)) : 32'd16;
    frames = $urandom_range(0, 6);
    dsize = 32'(frames * align + $urandom_range(0, align));
    n_data = (chans == 0) ? 3 : frames * chans * bps + $urandom_range(0, 4);
    if (sel < 10) fmt = 16'($urandom_range(4, 65535));
    else if (sel < 14) bits = 16'($urandom_range(33, 65535));
    else if (sel < 18 && fmt == wsd_pkg::FmtPcm) bits = 16'($urandom_range(0, 31) & ~16'h18);
    send_wave(fmt, chans, $urandom, align, bits, fsz, $urandom_range(0, 2), dsize,
              n_data, $urandom_range(0, 3),
              (sel >= 18 && sel < 21) ? 1 : (sel >= 21 && sel < 24) ? 2 : 0,
              (sel >= 24 && sel < 30) ? $urandom_range(1, 60) : 0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first idling phase: sender rarely idles, receiver often
    send_idle_pct = 8;
    recv_idle_pct = 70;

    // directed files: each depth and format, the errors and the edge cases
    send_wave(wsd_pkg::FmtPcm, 1, 32'd0, 1, 8, 16, 0, 4, 4, 2, 0, 0);
    send_wave(wsd_pkg::FmtPcm, 2, 32'hFFFF_FFFF, 4, 16, 18, 1, 8, 8, 0, 0, 0);
    send_wave(wsd_pkg::FmtPcm, 1, 32'd48000, 3, 24, 4, 0, 6, 6, 0, 0, 0);
    send_wave(wsd_pkg::FmtPcm, 1, 32'd44100, 4, 32, 16, 2, 8, 8, 1, 0, 0);
    send_wave(wsd_pkg::FmtFloat, 2, 32'd96000, 8, 32, 16, 0, 8, 8, 0, 0, 0);
    send_wave(wsd_pkg::FmtPcm, 1, 32'd8000, 2, 16, 16, 0, 32'hFFFF_FFFF, 6, 0, 0, 0);
    send_wave(wsd_pkg::FmtPcm, 2, 32'd1, 5, 8, 16, 0, 7, 3, 0, 0, 0);
    send_wave(wsd_pkg::FmtPcm, 1, 32'd1, 2, 16, 16, 0, 1, 2, 0, 0, 0);
    send_wave(wsd_pkg::FmtPcm, 0, 32'd1, 0, 16, 16, 0, 4, 4, 0, 0, 0);
    send_wave(wsd_pkg::FmtPcm, 1, 32'd1, 2, 16, 16, 0, 4, 4, 0, 1, 0);
    send_wave(wsd_pkg::FmtPcm, 1, 32'd1, 2, 16, 16, 0, 4, 4, 0, 2, 0);
    send_wave(wsd_pkg::FmtPcm, 1, 32'd1, 2, 16'hFFFF, 16, 0, 4, 4, 0, 0, 0);
    send_wave(wsd_pkg::FmtPcm, 1, 32'd1, 2, 12, 16, 0, 4, 4, 0, 0, 0);
    send_wave(16'hFFFF, 1, 32'd1, 2, 16, 16, 0, 4, 4, 0, 0, 0);
    send_wave(wsd_pkg::FmtPcm, 1, 32'd1, 2, 16, 16, 1, 4, 4, 0, 0, 30);

    // random files across the three idling phases
    while (bytes_sent < 900) random_file();
    send_idle_pct = 70;
    recv_idle_pct = 8;
    while (bytes_sent < 1150) random_file();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    while (bytes_sent < 1400) random_file();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
